### src/cesc_pkg.sv
// Package for the C escape decoder: item types of both channels and the
// decoded group type that passes from the front end to the back end.
// No dependencies.
`default_nettype none

package cesc_pkg;

  // Largest number of decoded bytes that one input item can release.
  localparam int unsigned MaxOut = 4;

  // One raw input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One decoded output item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // All bytes decoded from one input item, held in the queue as one entry.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;    // 1 to 4 valid bytes, lowest first
    logic                   last;   // the final byte closes the string
  } group_t;

endpackage

`default_nettype wire

### src/cesc_front.sv
// Front end of the C escape decoder: holds the bytes of an unfinished
// escape, decodes each accepted item and hands the decoded group onward.
// Depends on cesc_pkg.
`default_nettype none

module cesc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire cesc_pkg::in_item_t item_i,
  output logic                   push_o,
  output cesc_pkg::group_t       group_o
);
  import cesc_pkg::*;

  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;

  // Single-letter escapes: hit flag above the mapped byte.
  function automatic logic [8:0] letter_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      default: r = {1'b0, 8'd0};
    endcase
    return r;
  endfunction

  // Hex digit: valid flag above the four-bit value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      r = {1'b1, t[3:0]};
    end else if (c >= ChUpA && c <= ChUpF) begin
      t = c - ChUpA + 8'd10;
      r = {1'b1, t[3:0]};
    end else if (c >= ChLoA && c <= ChLoF) begin
      t = c - ChLoA + 8'd10;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  logic [2:0][7:0] pend_q, pend_d;
  logic [1:0]      cnt_q, cnt_d;
  group_t          grp;

  // Decode the held bytes plus the new one, at most four scan steps.
  always_comb begin
    logic [3:0][7:0] buf_b;
    logic [2:0]      n;
    logic [2:0]      pos;
    logic [2:0]      rem;
    logic            done;
    logic [7:0]      c, ec, d2, d3;
    logic [8:0]      lm;
    logic [4:0]      hh, hl;
    logic            numeric, num_ok;
    logic [7:0]      num_val;
    logic            last;

    buf_b   = '0;
    grp     = '0;
    last    = item_i.in_last;
    n       = {1'b0, cnt_q} + 3'd1;
    pos     = '0;
    done    = 1'b0;
    rem     = '0;
    c       = '0;
    ec      = '0;
    d2      = '0;
    d3      = '0;
    lm      = '0;
    hh      = '0;
    hl      = '0;
    numeric = 1'b0;
    num_ok  = 1'b0;
    num_val = '0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(cnt_q)) buf_b[i] = pend_q[i];
    end
    buf_b[cnt_q] = item_i.in_byte;

    for (int it = 0; it < MaxOut; it++) begin
      if (!done && pos < n) begin
        rem = n - pos;
        c   = buf_b[pos[1:0]];
        ec  = buf_b[pos[1:0] + 2'd1];
        d2  = buf_b[pos[1:0] + 2'd2];
        d3  = buf_b[pos[1:0] + 2'd3];
        lm  = letter_map(ec);
        hh  = hex_val(d2);
        hl  = hex_val(d3);
        numeric = (ec == ChX) || is_oct(ec);
        if (ec == ChX) begin
          num_ok  = hh[4] && hl[4];
          num_val = {hh[3:0], hl[3:0]};
        end else begin
          num_ok  = is_oct(d2) && is_oct(d3);
          num_val = {ec[1:0], d2[2:0], d3[2:0]};
        end
        if (c != ChBsl) begin
          // Plain byte passes straight through.
          grp.bytes[grp.cnt[1:0]] = c;
          grp.cnt = grp.cnt + 3'd1;
          pos = pos + 3'd1;
        end else if (rem < 3'd2) begin
          // Lone backslash: wait, or emit it at the end of the string.
          if (!last) begin
            done = 1'b1;
          end else begin
            grp.bytes[grp.cnt[1:0]] = ChBsl;
            grp.cnt = grp.cnt + 3'd1;
            pos = pos + 3'd1;
          end
        end else if (lm[8]) begin
          grp.bytes[grp.cnt[1:0]] = lm[7:0];
          grp.cnt = grp.cnt + 3'd1;
          pos = pos + 3'd2;
        end else if (numeric && rem < 3'd4 && !last) begin
          // Hex or octal escape still missing digits.
          done = 1'b1;
        end else if (numeric && rem == 3'd4 && num_ok) begin
          grp.bytes[grp.cnt[1:0]] = num_val;
          grp.cnt = grp.cnt + 3'd1;
          pos = pos + 3'd4;
        end else if (ec == ChZero) begin
          grp.bytes[grp.cnt[1:0]] = 8'd0;
          grp.cnt = grp.cnt + 3'd1;
          pos = pos + 3'd2;
        end else begin
          // Failed escape: the backslash passes and the rest is rescanned.
          grp.bytes[grp.cnt[1:0]] = ChBsl;
          grp.cnt = grp.cnt + 3'd1;
          pos = pos + 3'd1;
        end
      end
    end

    grp.last = last;
    cnt_d    = 2'(n - pos);
    for (int i = 0; i < 3; i++) begin
      pend_d[i] = buf_b[pos[1:0] + 2'(i)];
    end
  end

  // Held escape bytes are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (accept_i) pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign push_o  = accept_i && (grp.cnt != 3'd0);
  assign group_o = grp;

endmodule

`default_nettype wire

### src/cesc_queue.sv
// Short queue of decoded groups between the front and back ends of the
// C escape decoder. Depends on cesc_pkg.
`default_nettype none

module cesc_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire cesc_pkg::group_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output cesc_pkg::group_t      data_o
);
  import cesc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrMax) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrMax) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

### src/cesc_back.sv
// Back end of the C escape decoder: unpacks queued groups into single
// output items through a registered output stage. Depends on cesc_pkg.
`default_nettype none

module cesc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire cesc_pkg::group_t   head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cesc_pkg::out_item_t     out_item_o
);
  import cesc_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic      load_en, is_final;

  // The output register takes a new byte whenever it is empty or drained.
  always_comb begin
    load_en     = !out_valid_q || !out_stall_i;
    is_final    = ({1'b0, idx_q} == (head_i.cnt - 3'd1));
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load_en) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d.out_byte = head_i.bytes[idx_q];
        out_d.out_last = head_i.last && is_final;
        if (is_final) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### src/c_escape_decoder.sv
// Top level of the C escape decoder: front end, group queue and back end.
// Depends on cesc_pkg, cesc_front, cesc_queue and cesc_back.
//
// Usage: raw characters enter on the input channel (in_valid_i, in_stall_o,
// in_item_i), one per item, with in_last set on the final character of a
// string. Decoded characters leave on the output channel (out_valid_o,
// out_stall_i, out_item_o); out_last marks the final decoded character.
// An item is accepted on a rising edge with valid high and stall low.
// The front end decodes each item in the cycle it is accepted and writes
// the one to four bytes it releases, if any, as a single entry into a queue of
// QueueDepth entries. The back end drains one byte per cycle while out_stall_i
// is low, so a byte passes a queue entry and then the output register. Items
// are taken every cycle while the queue has room; the sustained rate is one
// item per cycle while out_stall_i is low and items release at most one byte
// each on average, and the four bytes of a failed escape leave the back end
// one at a time. in_stall_o rises only when the queue is full. While
// out_stall_i is high the output item holds and the queue fills. Reset
// empties the queue, the output register and any held escape.
`default_nettype none

module c_escape_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire cesc_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output cesc_pkg::out_item_t      out_item_o
);
  import cesc_pkg::*;

  logic   accept, push, full, pop, head_valid;
  group_t push_group, head_group;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cesc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .group_o  (push_group)
  );

  cesc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_group),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_group)
  );

  cesc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_group),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

### src/cesc_checker.sv
// Port-level checks for the C escape decoder, bound to its top level.
// Depends on cesc_pkg and c_escape_decoder.
`default_nettype none

module cesc_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_o,
  input  wire cesc_pkg::in_item_t  in_item_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_stall_i,
  input  wire cesc_pkg::out_item_t out_item_o
);

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // A stalled input item holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while stalled");

  // Reset leaves no output item pending.
  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // Reset leaves the queue empty, so input is not stalled.
  a_rst_in: assert property (@(posedge clk_i)
    !rst_ni |-> !in_stall_o)
    else $error("input stalled during reset");

  // The queue can only become full right after an item was accepted.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted item");

endmodule

bind c_escape_decoder cesc_checker u_cesc_checker (.*);

`default_nettype wire
